FILE: rtl/gdms_pkg.sv
// package for the gps degrees to dms rational converter
// types, constants and helper functions shared by gdms_div and the top level
// no dependencies
`default_nettype none

package gdms_pkg;

  localparam int VALUE_W = 39;
  localparam int REF_W   = 8;
  localparam int DEG_W   = 9;
  localparam int MIN_W   = 6;
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 20;
  localparam int DIV_W   = 40;
  localparam int QUO_W   = 32;
  localparam int REM_W   = 30;
  localparam int PROD_W  = 64;
  localparam int SEC_W   = 26;
  localparam int EXP_W   = 3;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 80;

  // constant divisors of the shared unit
  localparam logic [DIV_W-1:0] DSOR_NANO  = 40'd1000000000;
  localparam logic [DIV_W-1:0] DSOR_MILLI = 40'd1000;
  localparam logic [DIV_W-1:0] DSOR_HUND  = 40'd100;

  // truncated reciprocals: floor(2^52 / 1e9), floor(2^40 / 1000), floor(2^38 / 100)
  localparam logic [QUO_W-1:0] RECIP_NANO  = 32'd4503599;
  localparam logic [QUO_W-1:0] RECIP_MILLI = 32'd1099511627;
  localparam logic [QUO_W-1:0] RECIP_HUND  = 32'd2748779069;

  // dividend shift before the reciprocal multiply
  localparam int SH_NANO  = 20;
  localparam int SH_MILLI = 8;
  localparam int SH_HUND  = 7;

  localparam logic [VALUE_W-1:0] NANO      = 39'd1000000000;
  localparam logic [DIV_W-1:0]   ALT_ROUND = 40'd50;
  localparam logic [DIV_W-1:0]   SEC_ROUND = 40'd500;
  localparam logic [SEC_W-1:0]   SEC_WRAP  = 26'd60000000;
  localparam logic [MIN_W-1:0]   MIN_WRAP  = 6'd60;

  localparam logic [EXP_W-1:0] EXP_MICRO = 3'd6;
  localparam logic [EXP_W-1:0] EXP_ALT   = 3'd4;

  // exact division by five through the inverse mod 2^32
  localparam logic [NUM_W-1:0] INV5     = 32'hCCCCCCCD;
  localparam logic [NUM_W-1:0] DIV5_MAX = 32'h33333333;

  localparam logic [REF_W-1:0] CH_N    = 8'h4E;
  localparam logic [REF_W-1:0] CH_S    = 8'h53;
  localparam logic [REF_W-1:0] CH_E    = 8'h45;
  localparam logic [REF_W-1:0] CH_W    = 8'h57;
  localparam logic [REF_W-1:0] CH_ZERO = 8'h30;
  localparam logic [REF_W-1:0] REF_NONE  = 8'h00;
  localparam logic [REF_W-1:0] ALT_ABOVE = 8'h00;
  localparam logic [REF_W-1:0] ALT_BELOW = 8'h01;

  localparam int MODE_ALT_BIT = 1;
  localparam int MODE_LON_BIT = 0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEG,
    ST_MIN,
    ST_SEC,
    ST_ALT,
    ST_RED2,
    ST_RED5,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_EST,
    DV_BACK,
    DV_FIX
  } div_phase_t;

  typedef enum logic [1:0] {
    DK_NANO,
    DK_MILLI,
    DK_HUNDRED
  } div_kind_t;

  typedef struct packed {
    logic             start;
    div_kind_t        kind;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } div_sts_t;

  function automatic logic [DIV_W-1:0] times60(input logic [REM_W-1:0] r);
    logic [DIV_W-1:0] w;
    w = {{(DIV_W-REM_W){1'b0}}, r};
    return (w << 6) - (w << 2);
  endfunction

  function automatic logic [DEN_W-1:0] pow5(input logic [EXP_W-1:0] e);
    logic [DEN_W-1:0] p;
    unique case (e)
      3'd0: p = 20'd1;
      3'd1: p = 20'd5;
      3'd2: p = 20'd25;
      3'd3: p = 20'd125;
      3'd4: p = 20'd625;
      3'd5: p = 20'd3125;
      3'd6: p = 20'd15625;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

  function automatic logic [DEN_W-1:0] den_of(input logic [EXP_W-1:0] c2,
                                               input logic [EXP_W-1:0] c5);
    return pow5(c5) << c2;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gps_degrees_to_dms_rational_top.sv
// top level of the gps degrees to dms rational converter
// sequencer around the shared divider gdms_div; uses gdms_pkg
`default_nettype none

// Converts one latitude or longitude (signed nanodegrees) or altitude (signed
// micrometres) per transfer into a reference byte, whole degrees, minutes and
// a reduced seconds or metres fraction whose denominator divides one million.
// One item holds the input from its transfer to the next point where s_tready
// is high: an angle runs three divisions by a constant on the shared unit
// (each a reciprocal estimate, a back-multiply and compare-and-subtract
// checks until the remainder is below the divisor), an altitude of 1000 m or
// more one division by 100; then the fraction is halved and divided by five
// as far as the exponents allow and the result stays exact, and the output
// register is loaded. s_tready is high only between items; a finished result
// sits in the output register until it is taken and the next item waits
// behind it.

module gps_degrees_to_dms_rational_top
  import gdms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // value[38:0], ref_char[46:39], zero pad
  input  wire logic [1:0]       s_tuser,   // mode[1:0]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // ref_out, whole_degrees, minutes,
                                           // fraction_num, fraction_den, zero pad
);

  state_t             state, state_next;
  logic               m_tvalid_next;
  logic [REF_W-1:0]   ref_r, ref_next;
  logic [DEG_W-1:0]   deg, deg_next;
  logic [MIN_W-1:0]   mins, mins_next;
  logic [NUM_W-1:0]   x, x_next;
  logic [EXP_W-1:0]   c2, c2_next;
  logic [EXP_W-1:0]   c5, c5_next;
  logic [OUT_W-1:0]   out_data, out_data_next;

  div_req_t           req;
  div_sts_t           sts;
  logic [QUO_W-1:0]   quo;
  logic [REM_W-1:0]   rem;

  logic [VALUE_W-1:0] in_value;
  logic [REF_W-1:0]   in_ref;
  logic               in_neg;
  logic [VALUE_W-1:0] in_mag;
  logic [REF_W-1:0]   sign_ref;

  logic [SEC_W-1:0]   sec;
  logic               sec_carry;
  logic [MIN_W-1:0]   mins_c;
  logic [NUM_W-1:0]   prod5;
  logic               div5_ok;

  gdms_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .sts     (sts),
    .quo     (quo),
    .rem_out (rem)
  );

  assign in_value = s_tdata[VALUE_W-1:0];
  assign in_ref   = s_tdata[VALUE_W +: REF_W];
  assign in_neg   = in_value[VALUE_W-1];
  assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;

  always_comb begin
    if (s_tuser[MODE_LON_BIT]) begin
      sign_ref = in_neg ? CH_W : CH_E;
    end else begin
      sign_ref = in_neg ? CH_S : CH_N;
    end
  end

  assign sec       = quo[SEC_W-1:0];
  assign sec_carry = (sec >= SEC_WRAP);
  assign mins_c    = mins + {{(MIN_W-1){1'b0}}, sec_carry};

  assign prod5   = x * INV5;
  assign div5_ok = (prod5 <= DIV5_MAX);

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    ref_r    <= ref_next;
    deg      <= deg_next;
    mins     <= mins_next;
    x        <= x_next;
    c2       <= c2_next;
    c5       <= c5_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next    = state;
    m_tvalid_next = m_tvalid && !m_tready;
    ref_next      = ref_r;
    deg_next      = deg;
    mins_next     = mins;
    x_next        = x;
    c2_next       = c2;
    c5_next       = c5;
    out_data_next = out_data;
    req           = '0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          deg_next  = '0;
          mins_next = '0;
          if (s_tuser[MODE_ALT_BIT]) begin
            ref_next = (in_ref == CH_ZERO) ? ALT_ABOVE : ALT_BELOW;
            if (in_mag < NANO) begin
              x_next     = in_mag[NUM_W-1:0];
              c2_next    = EXP_MICRO;
              c5_next    = EXP_MICRO;
              state_next = ST_RED2;
            end else begin
              req.start    = 1'b1;
              req.kind     = DK_HUNDRED;
              req.dividend = {1'b0, in_mag} + ALT_ROUND;
              state_next   = ST_ALT;
            end
          end else begin
            ref_next     = (in_ref != REF_NONE) ? in_ref : sign_ref;
            req.start    = 1'b1;
            req.kind     = DK_NANO;
            req.dividend = {1'b0, in_mag};
            state_next   = ST_DEG;
          end
        end
      end
      ST_DEG: begin
        if (sts.fin) begin
          deg_next     = quo[DEG_W-1:0];
          req.start    = 1'b1;
          req.kind     = DK_NANO;
          req.dividend = times60(rem);
          state_next   = ST_MIN;
        end
      end
      ST_MIN: begin
        if (sts.fin) begin
          mins_next    = quo[MIN_W-1:0];
          req.start    = 1'b1;
          req.kind     = DK_MILLI;
          req.dividend = times60(rem) + SEC_ROUND;
          state_next   = ST_SEC;
        end
      end
      ST_SEC: begin
        if (sts.fin) begin
          x_next = {{(NUM_W-SEC_W){1'b0}}, sec_carry ? (sec - SEC_WRAP) : sec};
          if (mins_c == MIN_WRAP) begin
            mins_next = '0;
            deg_next  = deg + 1'b1;
          end else begin
            mins_next = mins_c;
          end
          c2_next    = EXP_MICRO;
          c5_next    = EXP_MICRO;
          state_next = ST_RED2;
        end
      end
      ST_ALT: begin
        if (sts.fin) begin
          x_next     = quo;
          c2_next    = EXP_ALT;
          c5_next    = EXP_ALT;
          state_next = ST_RED2;
        end
      end
      ST_RED2: begin
        if (c2 != '0 && !x[0]) begin
          x_next  = x >> 1;
          c2_next = c2 - 1'b1;
        end else begin
          state_next = ST_RED5;
        end
      end
      ST_RED5: begin
        if (c5 != '0 && div5_ok) begin
          x_next  = prod5;
          c5_next = c5 - 1'b1;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_data_next = {{(OUT_W-REF_W-DEG_W-MIN_W-NUM_W-DEN_W){1'b0}},
                           den_of(c2, c5), x, mins, deg, ref_r};
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[74:55] != '0))
    else $error("zero denominator on output");

  a_min_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[22:17] < MIN_WRAP))
    else $error("minutes out of range on output");

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !sts.busy)
    else $error("divider started while busy");

  a_fin_state: assert property (@(posedge clk) disable iff (rst)
    sts.fin |-> (state == ST_DEG || state == ST_MIN || state == ST_SEC ||
                 state == ST_ALT))
    else $error("divider finished outside a divide state");

endmodule

`default_nettype wire

FILE: rtl/gdms_div.sv
// division by a constant on one shared 32x32 multiplier: reciprocal estimate,
// back-multiply, then compare-and-subtract correction; uses gdms_pkg
`default_nettype none

module gdms_div
  import gdms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  output div_sts_t              sts,
  output logic [QUO_W-1:0]      quo,
  output logic [REM_W-1:0]      rem_out
);

  div_phase_t        phase, phase_next;
  div_kind_t         kind, kind_next;
  logic [DIV_W-1:0]  dvd, dvd_next;
  logic [DIV_W-1:0]  rem, rem_next;
  logic [QUO_W-1:0]  quo_next;
  logic              fin, fin_next;

  logic [DIV_W-1:0]  dsor;
  logic [QUO_W-1:0]  recip;
  logic [QUO_W-1:0]  dvd_hi;
  logic [QUO_W-1:0]  mul_a;
  logic [QUO_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  q_est;

  always_comb begin
    unique case (kind)
      DK_MILLI: begin
        dsor   = DSOR_MILLI;
        recip  = RECIP_MILLI;
        dvd_hi = QUO_W'(dvd >> SH_MILLI);
      end
      DK_HUNDRED: begin
        dsor   = DSOR_HUND;
        recip  = RECIP_HUND;
        dvd_hi = QUO_W'(dvd >> SH_HUND);
      end
      default: begin
        dsor   = DSOR_NANO;
        recip  = RECIP_NANO;
        dvd_hi = QUO_W'(dvd >> SH_NANO);
      end
    endcase
  end

  // shared multiplier
  assign prod  = {{(PROD_W-QUO_W){1'b0}}, mul_a} * {{(PROD_W-QUO_W){1'b0}}, mul_b};
  // estimate is low by at most two
  assign q_est = (kind == DK_HUNDRED) ? prod[PROD_W-2 -: QUO_W] : prod[PROD_W-1 -: QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DV_IDLE;
      fin   <= 1'b0;
      kind  <= DK_NANO;
    end else begin
      phase <= phase_next;
      fin   <= fin_next;
      kind  <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    dvd <= dvd_next;
    rem <= rem_next;
    quo <= quo_next;
  end

  always_comb begin
    phase_next = phase;
    kind_next  = kind;
    dvd_next   = dvd;
    rem_next   = rem;
    quo_next   = quo;
    fin_next   = 1'b0;
    mul_a      = dvd_hi;
    mul_b      = recip;

    unique case (phase)
      DV_IDLE: begin
        if (req.start) begin
          kind_next  = req.kind;
          dvd_next   = req.dividend;
          phase_next = DV_EST;
        end
      end
      DV_EST: begin
        quo_next   = q_est;
        phase_next = DV_BACK;
      end
      DV_BACK: begin
        mul_a      = quo;
        mul_b      = dsor[QUO_W-1:0];
        rem_next   = dvd - prod[DIV_W-1:0];
        phase_next = DV_FIX;
      end
      DV_FIX: begin
        if (rem >= dsor) begin
          rem_next = rem - dsor;
          quo_next = quo + 1'b1;
        end else begin
          fin_next   = 1'b1;
          phase_next = DV_IDLE;
        end
      end
    endcase
  end

  assign rem_out  = rem[REM_W-1:0];
  assign sts.busy = (phase != DV_IDLE);
  assign sts.fin  = fin;

endmodule

`default_nettype wire
